FILE: design/tss_pkg.sv
`default_nettype none

package tss_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 8;
  localparam int SEL_W       = 2;
  localparam int STATUS_W    = 2;
  // signed address math: covers -255 .. 510
  localparam int SW          = 11;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam int DEF_STORE_DEPTH = 256;
  localparam int DEF_FIRST_BASE  = 4;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [SEL_W-1:0] SEL_LOWER  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_MIDDLE = 2'd1;
  localparam logic [SEL_W-1:0] SEL_UPPER  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_LO,
    OP_PUSH_MID,
    OP_PUSH_UP,
    OP_POP_LO,
    OP_POP_MID,
    OP_POP_UP,
    OP_NOP
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
  } op_t;

endpackage

`default_nettype wire

FILE: design/tss_if.sv
`default_nettype none

interface tss_in_if import tss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SEL_W-1:0]  stack_select;
  logic [BYTE_W-1:0] push_byte;

  modport source (output valid, output command, output stack_select, output push_byte,
                  input ready);
  modport sink   (input valid, input command, input stack_select, input push_byte,
                  output ready);
endinterface

interface tss_out_if import tss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   pop_byte;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output pop_byte, output status, input ready);
  modport sink   (input valid, input pop_byte, input status, output ready);
endinterface

`default_nettype wire

FILE: design/three_stacks_shared_store.sv
// A push, an empty pop or an unused selector goes from the input queue to the result register;
// a successful pop also passes the registered store read, a refused push the planning state.
// A colliding push that fits adds the plan state and deferred write plus a read and a write per moved element.
// Throughput: one push per cycle while results are taken; a pop holds the back end until its read is back.
// Reset: stack lengths clear, middle base goes to two thirds of the store, the
// two-item input queue and the result register empty; store contents are not cleared.
`default_nettype none

module three_stacks_shared_store import tss_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int FIRST_BASE  = DEF_FIRST_BASE
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tss_in_if.sink    in_i,
  tss_out_if.source out_o
);

  logic op_valid;
  logic op_ready;
  op_t  op;

  tss_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_ready_i (op_ready)
  );

  tss_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .FIRST_BASE  (FIRST_BASE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

FILE: design/tss_front.sv
`default_nettype none

module tss_front import tss_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  tss_in_if.sink in_i,
  output logic   op_valid_o,
  output op_t    op_o,
  input  logic   op_ready_i
);

  localparam int CNT_W = QPTR_W + 1;

  op_t               entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  op_t               cls;
  logic              push;
  logic              pop;

  // decode command and selector into one operation code
  always_comb begin
    cls.data = in_i.push_byte;
    if (in_i.command == CMD_PUSH) begin
      case (in_i.stack_select)
        SEL_LOWER:  cls.op = OP_PUSH_LO;
        SEL_MIDDLE: cls.op = OP_PUSH_MID;
        SEL_UPPER:  cls.op = OP_PUSH_UP;
        default:    cls.op = OP_NOP;
      endcase
    end else begin
      case (in_i.stack_select)
        SEL_LOWER:  cls.op = OP_POP_LO;
        SEL_MIDDLE: cls.op = OP_POP_MID;
        SEL_UPPER:  cls.op = OP_POP_UP;
        default:    cls.op = OP_NOP;
      endcase
    end
  end

  assign in_i.ready = (count_q != CNT_W'(QUEUE_DEPTH));
  assign op_valid_o = (count_q != '0);
  assign op_o       = entries_q[rd_ptr_q];
  assign push       = in_i.valid && in_i.ready;
  assign pop        = op_valid_o && op_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/tss_back.sv
`default_nettype none

module tss_back import tss_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int FIRST_BASE  = DEF_FIRST_BASE
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_ready_o,
  tss_out_if.source out_o
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic signed [SW-1:0] TOP_S   = SW'(STORE_DEPTH - 1);
  localparam logic signed [SW-1:0] DEPTH_S = SW'(STORE_DEPTH);
  localparam logic signed [SW-1:0] FB_S    = SW'(FIRST_BASE);
  localparam logic signed [SW-1:0] ONE_S   = SW'(1);
  localparam logic [LEN_W-1:0] MID_BASE_RST = LEN_W'((STORE_DEPTH * 2 / 3) % 256);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PLAN,
    S_MV_RD,
    S_MV_WR,
    S_PUSH
  } state_e;

  function automatic logic signed [SW-1:0] ext(input logic [LEN_W-1:0] v);
    ext = $signed({{(SW-LEN_W){1'b0}}, v});
  endfunction

  logic [BYTE_W-1:0] mem [STORE_DEPTH];

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [BYTE_W-1:0]   data_q, data_d;
  logic [LEN_W-1:0]    ll_q, ll_d, ml_q, ml_d, ul_q, ul_d, mb_q, mb_d;
  logic signed [SW-1:0] ue_q, ue_d, le_q, le_d;
  logic [AW-1:0]       src_q, src_d, dst_q, dst_d;
  logic [LEN_W-1:0]    cnt_q, cnt_d;
  logic                asc_q, asc_d;
  logic                rd_ok_q, rd_ok_d;
  logic                out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]   out_byte_q, out_byte_d;
  status_e             out_status_q, out_status_d;
  logic [BYTE_W-1:0]   rdata_q;

  logic                slot_free;
  op_e                 cur_op;
  logic [BYTE_W-1:0]   cur_byte;
  logic signed [SW-1:0] lo_end, mid_end, up_end, mb_s, len_s;
  logic signed [SW-1:0] push_addr, pop_addr, gap, sum_half, nb, desc_src, desc_dst;
  logic                push_in, pop_in, collide, plan_bad, do_push;
  logic [LEN_W-1:0]    pop_len;
  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [BYTE_W-1:0]   wdata;
  logic                res_load;
  logic [BYTE_W-1:0]   res_byte;
  status_e             res_status;

  assign slot_free = !out_valid_q || out_o.ready;
  assign cur_op    = (state_q == S_IDLE) ? op_i.op : op_q;
  assign cur_byte  = (state_q == S_IDLE) ? op_i.data : data_q;

  assign mb_s    = ext(mb_q);
  assign len_s   = ext(ml_q);
  assign lo_end  = FB_S + ext(ll_q);
  assign mid_end = mb_s + len_s;
  assign up_end  = TOP_S - ext(ul_q);

  // relocation plan from the free gap captured at the collision
  assign gap      = ue_q - le_q;
  assign sum_half = (ue_q + le_q) >>> 1;
  assign nb       = sum_half - (len_s >>> 1);
  assign desc_src = mb_s + len_s - ONE_S;
  assign desc_dst = nb + len_s - ONE_S;
  assign plan_bad = (gap <= len_s + ONE_S) || nb[SW-1] ||
                    (nb + len_s > DEPTH_S) || (mid_end > DEPTH_S);

  always_comb begin
    case (cur_op)
      OP_PUSH_LO:  push_addr = lo_end;
      OP_PUSH_MID: push_addr = mid_end;
      default:     push_addr = up_end;
    endcase
    case (cur_op)
      OP_POP_LO: begin
        pop_addr = lo_end - ONE_S;
        pop_len  = ll_q;
      end
      OP_POP_MID: begin
        pop_addr = mid_end - ONE_S;
        pop_len  = ml_q;
      end
      default: begin
        pop_addr = up_end + ONE_S;
        pop_len  = ul_q;
      end
    endcase
  end

  assign push_in = !push_addr[SW-1] && (push_addr < DEPTH_S);
  assign pop_in  = !pop_addr[SW-1] && (pop_addr < DEPTH_S);
  assign collide = (cur_op == OP_PUSH_LO) ? (lo_end == mb_s) : (mid_end == up_end);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    data_d     = data_q;
    ll_d       = ll_q;
    ml_d       = ml_q;
    ul_d       = ul_q;
    mb_d       = mb_q;
    ue_d       = ue_q;
    le_d       = le_q;
    src_d      = src_q;
    dst_d      = dst_q;
    cnt_d      = cnt_q;
    asc_d      = asc_q;
    rd_ok_d    = rd_ok_q;
    op_ready_o = 1'b0;
    do_push    = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;
    res_load   = 1'b0;
    res_byte   = '0;
    res_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        op_ready_o = slot_free;
        if (op_valid_i && slot_free) begin
          op_d   = op_i.op;
          data_d = op_i.data;
          case (op_i.op)
            OP_PUSH_LO, OP_PUSH_MID, OP_PUSH_UP: begin
              if (collide) begin
                ue_d    = up_end;
                le_d    = lo_end;
                state_d = S_PLAN;
              end else begin
                do_push = 1'b1;
              end
            end
            OP_POP_LO, OP_POP_MID, OP_POP_UP: begin
              if (pop_len == '0) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                case (op_i.op)
                  OP_POP_LO:  ll_d = ll_q - 1'b1;
                  OP_POP_MID: ml_d = ml_q - 1'b1;
                  default:    ul_d = ul_q - 1'b1;
                endcase
                re      = pop_in;
                raddr   = pop_addr[AW-1:0];
                rd_ok_d = pop_in;
                state_d = S_POP;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_POP: begin
        if (slot_free) begin
          res_load = 1'b1;
          res_byte = rd_ok_q ? rdata_q : '0;
          state_d  = S_IDLE;
        end
      end
      S_PLAN: begin
        if (plan_bad) begin
          if (slot_free) begin
            res_load   = 1'b1;
            res_status = ST_FULL;
            state_d    = S_IDLE;
          end
        end else begin
          mb_d = nb[LEN_W-1:0];
          if (ml_q != '0 && nb != mb_s) begin
            // overlapping move: copy away from the side being overwritten
            asc_d   = (nb < mb_s);
            src_d   = (nb < mb_s) ? mb_s[AW-1:0] : desc_src[AW-1:0];
            dst_d   = (nb < mb_s) ? nb[AW-1:0] : desc_dst[AW-1:0];
            cnt_d   = ml_q;
            state_d = S_MV_RD;
          end else begin
            state_d = S_PUSH;
          end
        end
      end
      S_MV_RD: begin
        re      = 1'b1;
        raddr   = src_q;
        state_d = S_MV_WR;
      end
      S_MV_WR: begin
        we      = 1'b1;
        waddr   = dst_q;
        wdata   = rdata_q;
        src_d   = asc_q ? src_q + 1'b1 : src_q - 1'b1;
        dst_d   = asc_q ? dst_q + 1'b1 : dst_q - 1'b1;
        cnt_d   = cnt_q - 1'b1;
        state_d = (cnt_q == LEN_W'(1)) ? S_PUSH : S_MV_RD;
      end
      S_PUSH: begin
        if (slot_free) begin
          do_push = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (do_push) begin
      we       = push_in;
      waddr    = push_addr[AW-1:0];
      wdata    = cur_byte;
      res_load = 1'b1;
      state_d  = S_IDLE;
      case (cur_op)
        OP_PUSH_LO:  ll_d = ll_q + 1'b1;
        OP_PUSH_MID: ml_d = ml_q + 1'b1;
        default:     ul_d = ul_q + 1'b1;
      endcase
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    if (res_load) begin
      out_valid_d  = 1'b1;
      out_byte_d   = res_byte;
      out_status_d = res_status;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.pop_byte = out_byte_q;
  assign out_o.status   = out_status_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_NOP;
      data_q       <= '0;
      ll_q         <= '0;
      ml_q         <= '0;
      ul_q         <= '0;
      mb_q         <= MID_BASE_RST;
      ue_q         <= '0;
      le_q         <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      cnt_q        <= '0;
      asc_q        <= 1'b0;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      data_q       <= data_d;
      ll_q         <= ll_d;
      ml_q         <= ml_d;
      ul_q         <= ul_d;
      mb_q         <= mb_d;
      ue_q         <= ue_d;
      le_q         <= le_d;
      src_q        <= src_d;
      dst_q        <= dst_d;
      cnt_q        <= cnt_d;
      asc_q        <= asc_d;
      rd_ok_q      <= rd_ok_d;
      out_valid_q  <= out_valid_d;
      out_byte_q   <= out_byte_d;
      out_status_q <= out_status_d;
    end
  end

  a_move_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MV_WR |-> $past(state_q) == S_MV_RD)
    else $error("move write without a preceding read");

  a_move_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MV_RD || state_q == S_MV_WR) |-> cnt_q != '0)
    else $error("middle stack move running with zero count");

  a_base_moves_on_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mb_q != $past(mb_q) |-> $past(state_q) == S_PLAN)
    else $error("middle base changed outside relocation");

  a_full_from_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_status == ST_FULL) |-> state_q == S_PLAN)
    else $error("full status without a relocation attempt");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
  import tss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = DEF_STORE_DEPTH;
  localparam int FIRST_BASE  = DEF_FIRST_BASE;
  localparam int TOP_ADDR    = STORE_DEPTH - 1;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 20;

  localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;

  typedef struct {
    logic [BYTE_W-1:0] pop_byte;
    status_e           status;
  } result_t;

  typedef struct {
    logic              cmd;
    logic [SEL_W-1:0]  sel;
    logic [BYTE_W-1:0] data;
    bit                typed;
    logic [BYTE_W-1:0] want_byte;
    status_e           want_status;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tss_in_if  in_if ();
  tss_out_if out_if ();

  three_stacks_shared_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow copy of the stacks
  logic [BYTE_W-1:0] shadow_mem [STORE_DEPTH];
  logic [LEN_W-1:0]  lower_len;
  logic [LEN_W-1:0]  middle_len;
  logic [LEN_W-1:0]  upper_len;
  logic [LEN_W-1:0]  middle_base;

  result_t pending_results [$];

  // side info for the item currently on the input channel
  bit                cur_typed;
  logic [BYTE_W-1:0] cur_want_byte;
  status_e           cur_want_status;

  int fail_count;
  int items_sent;
  int results_seen;
  int full_seen;
  int empty_seen;
  int moves_seen;
  int calm_left;

  stim_row_t directed_rows [22] = '{
    '{CMD_POP,  SEL_LOWER,  8'h00, 1'b1, 8'h00, ST_EMPTY},
    '{CMD_POP,  SEL_MIDDLE, 8'hFF, 1'b1, 8'h00, ST_EMPTY},
    '{CMD_POP,  SEL_UPPER,  8'h5A, 1'b1, 8'h00, ST_EMPTY},
    '{CMD_POP,  SEL_UNUSED, 8'h00, 1'b1, 8'h00, ST_OK},
    '{CMD_PUSH, SEL_UNUSED, 8'hFF, 1'b1, 8'h00, ST_OK},
    '{CMD_PUSH, SEL_LOWER,  8'hFF, 1'b1, 8'h00, ST_OK},
    '{CMD_PUSH, SEL_LOWER,  8'h00, 1'b1, 8'h00, ST_OK},
    '{CMD_POP,  SEL_LOWER,  8'hFF, 1'b1, 8'h00, ST_OK},
    '{CMD_POP,  SEL_LOWER,  8'h00, 1'b1, 8'hFF, ST_OK},
    '{CMD_POP,  SEL_LOWER,  8'h00, 1'b1, 8'h00, ST_EMPTY},
    '{CMD_PUSH, SEL_MIDDLE, 8'h80, 1'b1, 8'h00, ST_OK},
    '{CMD_PUSH, SEL_MIDDLE, 8'h7F, 1'b1, 8'h00, ST_OK},
    '{CMD_POP,  SEL_MIDDLE, 8'h00, 1'b1, 8'h7F, ST_OK},
    '{CMD_PUSH, SEL_UPPER,  8'h01, 1'b1, 8'h00, ST_OK},
    '{CMD_PUSH, SEL_UPPER,  8'hFE, 1'b1, 8'h00, ST_OK},
    '{CMD_POP,  SEL_UPPER,  8'h00, 1'b1, 8'hFE, ST_OK},
    '{CMD_POP,  SEL_UPPER,  8'h00, 1'b1, 8'h01, ST_OK},
    '{CMD_POP,  SEL_MIDDLE, 8'h00, 1'b1, 8'h80, ST_OK},
    '{CMD_POP,  SEL_MIDDLE, 8'h00, 1'b1, 8'h00, ST_EMPTY},
    '{CMD_PUSH, SEL_UPPER,  8'h55, 1'b1, 8'h00, ST_OK},
    '{CMD_POP,  SEL_UNUSED, 8'hAA, 1'b1, 8'h00, ST_OK},
    '{CMD_POP,  SEL_UPPER,  8'h00, 1'b1, 8'h55, ST_OK}
  };

  // Center the middle stack in the free gap; 0 when the store is full.
  function automatic bit recenter_middle();
    int up_end;
    int lo_end;
    int len;
    int old_b;
    int new_b;
    logic [BYTE_W-1:0] tmp [STORE_DEPTH];
    up_end = TOP_ADDR - int'(upper_len);
    lo_end = FIRST_BASE + int'(lower_len);
    len    = int'(middle_len);
    old_b  = int'(middle_base);
    if (up_end - lo_end <= len + 1) return 1'b0;
    new_b = (up_end + lo_end) / 2 - len / 2;
    if (new_b < 0 || new_b + len > STORE_DEPTH || old_b + len > STORE_DEPTH) return 1'b0;
    if (len > 0 && new_b != old_b) begin
      for (int i = 0; i < len; i++) tmp[i] = shadow_mem[old_b + i];
      for (int i = 0; i < len; i++) shadow_mem[new_b + i] = tmp[i];
      moves_seen++;
    end
    middle_base = new_b[LEN_W-1:0];
    return 1'b1;
  endfunction

  function automatic result_t predict_stacks(input logic cmd, input logic [SEL_W-1:0] sel,
                                             input logic [BYTE_W-1:0] data);
    result_t res;
    int slot;
    res.pop_byte = '0;
    res.status   = ST_OK;
    if (cmd == CMD_PUSH) begin
      case (sel)
        SEL_LOWER: begin
          slot = FIRST_BASE + int'(lower_len);
          if (slot == int'(middle_base) && !recenter_middle()) begin
            res.status = ST_FULL;
          end else begin
            shadow_mem[slot] = data;
            lower_len++;
          end
        end
        SEL_MIDDLE: begin
          slot = int'(middle_base) + int'(middle_len);
          if (slot == TOP_ADDR - int'(upper_len) && !recenter_middle()) begin
            res.status = ST_FULL;
          end else begin
            // base may have moved
            shadow_mem[int'(middle_base) + int'(middle_len)] = data;
            middle_len++;
          end
        end
        SEL_UPPER: begin
          slot = TOP_ADDR - int'(upper_len);
          if (slot == int'(middle_base) + int'(middle_len) && !recenter_middle()) begin
            res.status = ST_FULL;
          end else begin
            shadow_mem[slot] = data;
            upper_len++;
          end
        end
        default: ;
      endcase
    end else begin
      case (sel)
        SEL_LOWER: begin
          if (lower_len == 0) begin
            res.status = ST_EMPTY;
          end else begin
            lower_len--;
            res.pop_byte = shadow_mem[FIRST_BASE + int'(lower_len)];
          end
        end
        SEL_MIDDLE: begin
          if (middle_len == 0) begin
            res.status = ST_EMPTY;
          end else begin
            middle_len--;
            res.pop_byte = shadow_mem[int'(middle_base) + int'(middle_len)];
          end
        end
        SEL_UPPER: begin
          if (upper_len == 0) begin
            res.status = ST_EMPTY;
          end else begin
            upper_len--;
            res.pop_byte = shadow_mem[TOP_ADDR - int'(upper_len)];
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // Scoreboard: outputs are checked before the new input is predicted.
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.pop_byte = out_if.pop_byte;
        got.status   = status_e'(out_if.status);
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: pop_byte %0h, status %0d",
                 got.pop_byte, got.status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.pop_byte !== want.pop_byte) begin
            $error("pop_byte mismatch: expected %0h, got %0h", want.pop_byte, got.pop_byte);
            fail_count++;
          end
          if (out_if.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_if.status);
            fail_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        want = predict_stacks(in_if.command, in_if.stack_select, in_if.push_byte);
        if (cur_typed) begin
          want.pop_byte = cur_want_byte;
          want.status   = cur_want_status;
        end
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
        pending_results.push_back(want);
        items_sent++;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    int idle_cycles;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d results pending",
                 IDLE_LIMIT, pending_results.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Result side back-pressure.
  initial begin
    int hi;
    int lo;
    int r;
    out_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        hi = $urandom_range(50, 150);
        lo = 0;
      end else begin
        hi = $urandom_range(1, 8);
        r  = $urandom_range(0, 99);
        lo = (r < 75) ? $urandom_range(1, 3) : (r < 95) ? $urandom_range(4, 10) :
             $urandom_range(20, 40);
      end
      out_if.ready <= 1'b1;
      repeat (hi) @(negedge clk_i);
      if (lo > 0) begin
        out_if.ready <= 1'b0;
        repeat (lo) @(negedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called and returns at a falling edge.
  task automatic send_item(input logic cmd, input logic [SEL_W-1:0] sel,
                           input logic [BYTE_W-1:0] data, input bit typed,
                           input logic [BYTE_W-1:0] want_byte, input status_e want_status);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.stack_select <= sel;
    in_if.push_byte    <= data;
    cur_typed          <= typed;
    cur_want_byte      <= want_byte;
    cur_want_status    <= want_status;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count, input int push_pct);
    logic              cmd;
    logic [SEL_W-1:0]  sel;
    for (int n = 0; n < count; n++) begin
      cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
      sel = ($urandom_range(0, 99) < 4) ? SEL_UNUSED : SEL_W'($urandom_range(0, 2));
      send_item(cmd, sel, BYTE_W'($urandom_range(0, 255)), 1'b0, '0, ST_OK);
    end
  endtask

  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    in_if.valid        = 1'b0;
    in_if.command      = CMD_PUSH;
    in_if.stack_select = SEL_LOWER;
    in_if.push_byte    = '0;
    cur_typed          = 1'b0;
    cur_want_byte      = '0;
    cur_want_status    = ST_OK;
    fail_count   = 0;
    items_sent   = 0;
    results_seen = 0;
    full_seen    = 0;
    empty_seen   = 0;
    moves_seen   = 0;
    calm_left    = 0;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_mem[i] = '0;
    lower_len   = '0;
    middle_len  = '0;
    upper_len   = '0;
    middle_base = LEN_W'((STORE_DEPTH * 2) / 3);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].sel, directed_rows[i].data,
                directed_rows[i].typed, directed_rows[i].want_byte,
                directed_rows[i].want_status);
    end

    send_random(130, 55);
    // push-heavy burst to fill the store, then hold off until all results are back
    send_random(270, 95);
    wait_results_done();
    repeat ($urandom_range(1, 10)) @(negedge clk_i);
    send_random(180, 10);
    send_random(100, 55);

    wait_results_done();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("%0d items sent, %0d results checked", items_sent, results_seen);
    $display("%0d pushes refused as full, %0d empty pops, %0d middle stack moves",
             full_seen, empty_seen, moves_seen);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
